// ===== sv/phc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the pixel highlight compressor: luminance weights,
// scale fraction width and knee/cap levels. No dependencies.
package phc_pkg;

    // 16-bit fractional luminance weights, summing to 65536
    localparam logic [15:0] W_RED   = 16'd13933;
    localparam logic [15:0] W_GREEN = 16'd46871;
    localparam logic [15:0] W_BLUE  = 16'd4732;

    localparam int WEIGHT_BITS = 16;
    localparam int SCALE_BITS  = 16;

    localparam int KNEE_PCT = 82;
    localparam int CAP_PCT  = 90;

    // Knee and cap as channel codes, rounded to nearest
    function automatic int knee_code(input int bits);
        return (KNEE_PCT * (1 << bits) + 50) / 100;
    endfunction

    function automatic int cap_code(input int bits);
        return (CAP_PCT * (1 << bits) + 50) / 100;
    endfunction

endpackage

// ===== sv/phc_luma.sv =====
`timescale 1ns / 1ps
// Luminance front end: weighted channel sum, knee test and clamped excess.
// Three register stages. Depends on phc_pkg.
module phc_luma #(
    parameter int CHANNEL_BITS = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [CHANNEL_BITS-1:0] red_in,
    input  logic [CHANNEL_BITS-1:0] green_in,
    input  logic [CHANNEL_BITS-1:0] blue_in,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [CHANNEL_BITS-1:0] red_out,
    output logic [CHANNEL_BITS-1:0] green_out,
    output logic [CHANNEL_BITS-1:0] blue_out,
    output logic [CHANNEL_BITS-1:0] lum_out,
    output logic                    bright_out,
    output logic [CHANNEL_BITS-1:0] excess_out
);
    import phc_pkg::*;

    localparam int B    = CHANNEL_BITS;
    localparam int NS   = 3;
    localparam int PW   = WEIGHT_BITS + B;
    localparam int KNEE = knee_code(B);
    localparam int SPAN = (1 << B) - KNEE;

    localparam logic [B-1:0] KNEE_C = B'(KNEE);
    localparam logic [B-1:0] SPAN_C = B'(SPAN);

    logic [NS-1:0] v_reg;
    logic [NS:0]   rdy;
    logic [NS-1:0] v_in;
    logic [NS-1:0] ld;

    assign rdy[NS]   = out_ready;
    assign v_in      = {v_reg[NS-2:0], in_valid};
    assign ld        = rdy[NS-1:0] & v_in;
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NS-1];

    for (genvar i = 0; i < NS; i++)
    begin : g_rdy
        assign rdy[i] = !v_reg[i] || rdy[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_in[i];
                end
            end
        end
    end

    // stage 0: weighted products
    logic [B-1:0]  r0_reg, g0_reg, b0_reg;
    logic [PW-1:0] pr0_reg, pg0_reg, pb0_reg;
    // stage 1: luminance
    logic [B-1:0]  r1_reg, g1_reg, b1_reg, lum1_reg;
    // stage 2: knee test
    logic [B-1:0]  r2_reg, g2_reg, b2_reg, lum2_reg, ex2_reg;
    logic          bright2_reg;

    logic [PW-1:0] sum1_next;
    logic          bright2_next;
    logic [B-1:0]  ex_raw;
    logic [B-1:0]  ex2_next;

    // weights sum to 2^16, so the total fits PW bits
    assign sum1_next    = pr0_reg + pg0_reg + pb0_reg;
    assign bright2_next = lum1_reg > KNEE_C;
    assign ex_raw       = lum1_reg - KNEE_C;
    assign ex2_next     = !bright2_next ? '0 : ((ex_raw > SPAN_C) ? SPAN_C : ex_raw);

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            r0_reg  <= red_in;
            g0_reg  <= green_in;
            b0_reg  <= blue_in;
            pr0_reg <= PW'(W_RED) * PW'(red_in);
            pg0_reg <= PW'(W_GREEN) * PW'(green_in);
            pb0_reg <= PW'(W_BLUE) * PW'(blue_in);
        end
        if (ld[1])
        begin
            r1_reg   <= r0_reg;
            g1_reg   <= g0_reg;
            b1_reg   <= b0_reg;
            lum1_reg <= sum1_next[PW-1:WEIGHT_BITS];
        end
        if (ld[2])
        begin
            r2_reg      <= r1_reg;
            g2_reg      <= g1_reg;
            b2_reg      <= b1_reg;
            lum2_reg    <= lum1_reg;
            bright2_reg <= bright2_next;
            ex2_reg     <= ex2_next;
        end
    end

    assign red_out    = r2_reg;
    assign green_out  = g2_reg;
    assign blue_out   = b2_reg;
    assign lum_out    = lum2_reg;
    assign bright_out = bright2_reg;
    assign excess_out = ex2_reg;

endmodule

// ===== sv/phc_target.sv =====
`timescale 1ns / 1ps
// Target luminance: knee + floor((cap - knee) * excess / span), with the
// constant divide done by reciprocal multiply and one correction step.
// Four register stages. Depends on phc_pkg.
module phc_target #(
    parameter int CHANNEL_BITS = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [CHANNEL_BITS-1:0] red_in,
    input  logic [CHANNEL_BITS-1:0] green_in,
    input  logic [CHANNEL_BITS-1:0] blue_in,
    input  logic [CHANNEL_BITS-1:0] lum_in,
    input  logic                    bright_in,
    input  logic [CHANNEL_BITS-1:0] excess_in,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [CHANNEL_BITS-1:0] red_out,
    output logic [CHANNEL_BITS-1:0] green_out,
    output logic [CHANNEL_BITS-1:0] blue_out,
    output logic [CHANNEL_BITS-1:0] lum_out,
    output logic                    bright_out,
    output logic [CHANNEL_BITS-1:0] target_out
);
    import phc_pkg::*;

    localparam int B     = CHANNEL_BITS;
    localparam int NS    = 4;
    localparam int NW    = 2 * B;
    localparam int KNEE  = knee_code(B);
    localparam int SPAN  = (1 << B) - KNEE;
    localparam int DIFF  = cap_code(B) - KNEE;
    // reciprocal of span with 2B fraction bits; numerator stays below 2^(2B)
    localparam longint RECIP = (64'd1 << NW) / SPAN;
    localparam int RW    = $clog2(RECIP + 1);
    localparam int PW    = NW + RW;
    localparam int CW    = 4 * B + 1;

    localparam logic [B-1:0]  KNEE_C  = B'(KNEE);
    localparam logic [NW-1:0] SPAN_C  = NW'(SPAN);
    localparam logic [NW-1:0] DIFF_C  = NW'(DIFF);
    localparam logic [PW-1:0] RECIP_C = PW'(RECIP);

    logic [NS-1:0] v_reg;
    logic [NS:0]   rdy;
    logic [NS-1:0] v_in;
    logic [NS-1:0] ld;

    assign rdy[NS]   = out_ready;
    assign v_in      = {v_reg[NS-2:0], in_valid};
    assign ld        = rdy[NS-1:0] & v_in;
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NS-1];

    for (genvar i = 0; i < NS; i++)
    begin : g_rdy
        assign rdy[i] = !v_reg[i] || rdy[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_in[i];
                end
            end
        end
    end

    // pixel, luminance and bright flag ride along: {bright, lum, blue, green, red}
    logic [CW-1:0] com_reg [NS];
    logic [NW-1:0] n0_reg, n1_reg, n2_reg;
    logic [PW-1:0] p1_reg;
    logic [B-1:0]  q2_reg;
    logic [NW-1:0] qs2_reg;
    logic [B-1:0]  target3_reg;

    logic [B-1:0]  q2_next;
    logic [NW-1:0] rem3;
    logic          bump3;

    assign q2_next = p1_reg[NW +: B];
    assign rem3    = n2_reg - qs2_reg;
    // estimate is low by at most one
    assign bump3   = rem3 >= SPAN_C;

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            com_reg[0] <= {bright_in, lum_in, blue_in, green_in, red_in};
            n0_reg     <= DIFF_C * NW'(excess_in);
        end
        if (ld[1])
        begin
            com_reg[1] <= com_reg[0];
            n1_reg     <= n0_reg;
            p1_reg     <= PW'(n0_reg) * RECIP_C;
        end
        if (ld[2])
        begin
            com_reg[2] <= com_reg[1];
            n2_reg     <= n1_reg;
            q2_reg     <= q2_next;
            qs2_reg    <= NW'(q2_next) * SPAN_C;
        end
        if (ld[3])
        begin
            com_reg[3]  <= com_reg[2];
            target3_reg <= KNEE_C + q2_reg + B'(bump3);
        end
    end

    assign red_out    = com_reg[NS-1][B-1:0];
    assign green_out  = com_reg[NS-1][2*B-1:B];
    assign blue_out   = com_reg[NS-1][3*B-1:2*B];
    assign lum_out    = com_reg[NS-1][4*B-1:3*B];
    assign bright_out = com_reg[NS-1][4*B];
    assign target_out = target3_reg;

endmodule

// ===== sv/phc_divider.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider: scale = floor(target * 2^16 / lum), one
// quotient bit per stage. Target is always below lum on the bright path.
// Depends on phc_pkg.
module phc_divider #(
    parameter int CHANNEL_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [CHANNEL_BITS-1:0]      red_in,
    input  logic [CHANNEL_BITS-1:0]      green_in,
    input  logic [CHANNEL_BITS-1:0]      blue_in,
    input  logic [CHANNEL_BITS-1:0]      lum_in,
    input  logic                         bright_in,
    input  logic [CHANNEL_BITS-1:0]      target_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [CHANNEL_BITS-1:0]      red_out,
    output logic [CHANNEL_BITS-1:0]      green_out,
    output logic [CHANNEL_BITS-1:0]      blue_out,
    output logic                         bright_out,
    output logic [phc_pkg::SCALE_BITS-1:0] scale_out
);
    import phc_pkg::*;

    localparam int B  = CHANNEL_BITS;
    localparam int NS = SCALE_BITS;
    localparam int CW = 4 * B + 1;

    logic [NS-1:0] v_reg;
    logic [NS:0]   rdy;
    logic [NS-1:0] v_in;
    logic [NS-1:0] ld;

    assign rdy[NS]   = out_ready;
    assign v_in      = {v_reg[NS-2:0], in_valid};
    assign ld        = rdy[NS-1:0] & v_in;
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NS-1];

    for (genvar i = 0; i < NS; i++)
    begin : g_rdy
        assign rdy[i] = !v_reg[i] || rdy[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_in[i];
                end
            end
        end
    end

    // {bright, lum, blue, green, red}
    logic [CW-1:0] com_reg [NS];
    logic [NS-1:0] quo_reg [NS];
    logic [B-1:0]  rem_reg [NS-1];

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic [CW-1:0] com_in;
        logic [NS-1:0] quo_in;
        logic [B-1:0]  rem_in;
        logic [B:0]    shifted;
        logic [B:0]    divisor;
        logic          take;

        if (k == 0)
        begin : g_first
            assign com_in = {bright_in, lum_in, blue_in, green_in, red_in};
            assign quo_in = '0;
            assign rem_in = target_in;
        end
        else
        begin : g_rest
            assign com_in = com_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign rem_in = rem_reg[k-1];
        end

        assign shifted = {rem_in, 1'b0};
        assign divisor = {1'b0, com_in[4*B-1:3*B]};
        assign take    = shifted >= divisor;

        always_ff @(posedge clk)
        begin
            if (ld[k])
            begin
                com_reg[k] <= com_in;
                quo_reg[k] <= {quo_in[NS-2:0], take};
            end
        end

        // partial remainder stays below lum, so B bits hold it
        if (k < NS - 1)
        begin : g_rem
            logic [B:0] diff;
            assign diff = shifted - divisor;
            always_ff @(posedge clk)
            begin
                if (ld[k])
                begin
                    rem_reg[k] <= take ? diff[B-1:0] : shifted[B-1:0];
                end
            end
        end
    end

    assign red_out    = com_reg[NS-1][B-1:0];
    assign green_out  = com_reg[NS-1][2*B-1:B];
    assign blue_out   = com_reg[NS-1][3*B-1:2*B];
    assign bright_out = com_reg[NS-1][4*B];
    assign scale_out  = quo_reg[NS-1];

endmodule

// ===== sv/pixel_highlight_compressor.sv =====
`timescale 1ns / 1ps
// Pixel highlight compressor top level: stream ports, output scaling stage.
// Instantiates phc_luma, phc_target and phc_divider; depends on phc_pkg.
//
// Usage:
//   One RGB pixel per transfer on the slave side (s_tvalid/s_tready/s_tdata),
//   one compressed pixel per transfer on the master side, in the same order.
//   Pixels with luminance at or below the knee leave unchanged; brighter ones
//   are scaled toward the cap with hue kept.
//   24 register stages: 3 luminance stages, 4 target stages, 16 divider
//   stages (one quotient bit each) and the output multiply register.
//   Throughput is one pixel per clock while m_tready is high; every stage
//   holds one pixel.
//   Each stage has its own valid bit and loads when it is empty or its
//   successor moves, so while m_tready is low the pipeline keeps taking
//   input until every stage is full, and nothing is dropped or repeated.
//   Reset (rst_n low, asynchronous) empties the pipeline; no pixel in flight
//   survives it.
module pixel_highlight_compressor #(
    parameter  int CHANNEL_BITS = 12,
    localparam int TDATA_W      = ((3 * CHANNEL_BITS + 7) / 8) * 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // red_in, green_in, blue_in, zero pad
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata    // red_out, green_out, blue_out, zero pad
);
    import phc_pkg::*;

    localparam int B  = CHANNEL_BITS;
    localparam int MW = B + SCALE_BITS;

    logic [B-1:0] red_in, green_in, blue_in;
    assign red_in   = s_tdata[B-1:0];
    assign green_in = s_tdata[2*B-1:B];
    assign blue_in  = s_tdata[3*B-1:2*B];

    logic         l_valid, l_ready;
    logic [B-1:0] l_red, l_green, l_blue, l_lum, l_excess;
    logic         l_bright;

    phc_luma #(.CHANNEL_BITS(B)) u_luma (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .out_valid  (l_valid),
        .out_ready  (l_ready),
        .red_out    (l_red),
        .green_out  (l_green),
        .blue_out   (l_blue),
        .lum_out    (l_lum),
        .bright_out (l_bright),
        .excess_out (l_excess)
    );

    logic         t_valid, t_ready;
    logic [B-1:0] t_red, t_green, t_blue, t_lum, t_target;
    logic         t_bright;

    phc_target #(.CHANNEL_BITS(B)) u_target (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (l_valid),
        .in_ready   (l_ready),
        .red_in     (l_red),
        .green_in   (l_green),
        .blue_in    (l_blue),
        .lum_in     (l_lum),
        .bright_in  (l_bright),
        .excess_in  (l_excess),
        .out_valid  (t_valid),
        .out_ready  (t_ready),
        .red_out    (t_red),
        .green_out  (t_green),
        .blue_out   (t_blue),
        .lum_out    (t_lum),
        .bright_out (t_bright),
        .target_out (t_target)
    );

    logic                  d_valid, d_ready;
    logic [B-1:0]          d_red, d_green, d_blue;
    logic                  d_bright;
    logic [SCALE_BITS-1:0] d_scale;

    phc_divider #(.CHANNEL_BITS(B)) u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (t_valid),
        .in_ready   (t_ready),
        .red_in     (t_red),
        .green_in   (t_green),
        .blue_in    (t_blue),
        .lum_in     (t_lum),
        .bright_in  (t_bright),
        .target_in  (t_target),
        .out_valid  (d_valid),
        .out_ready  (d_ready),
        .red_out    (d_red),
        .green_out  (d_green),
        .blue_out   (d_blue),
        .bright_out (d_bright),
        .scale_out  (d_scale)
    );

    // output stage: channel * scale, keep the integer part
    logic               out_valid_reg;
    logic [TDATA_W-1:0] out_data_reg;
    logic [MW-1:0]      prod_r, prod_g, prod_b;
    logic [B-1:0]       red_c, green_c, blue_c;

    assign d_ready = !out_valid_reg || m_tready;
    assign prod_r  = MW'(d_red) * MW'(d_scale);
    assign prod_g  = MW'(d_green) * MW'(d_scale);
    assign prod_b  = MW'(d_blue) * MW'(d_scale);
    assign red_c   = d_bright ? prod_r[SCALE_BITS +: B] : d_red;
    assign green_c = d_bright ? prod_g[SCALE_BITS +: B] : d_green;
    assign blue_c  = d_bright ? prod_b[SCALE_BITS +: B] : d_blue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (d_ready)
        begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_ready && d_valid)
        begin
            out_data_reg <= TDATA_W'({blue_c, green_c, red_c});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
